// ===== src/mnrm_pkg.sv =====
// Shared types, constants and key tables for the MIDI note relay mapper.
package mnrm_pkg;

   localparam int OP_WIDTH      = 2;
   localparam int CHANNEL_WIDTH = 4;
   localparam int NOTE_WIDTH    = 7;
   localparam int RELAY_WIDTH   = 8;
   localparam int STATUS_WIDTH  = 3;
   localparam int CHANNELS      = 16;
   localparam int DIRECT_KEYS   = 8;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [NOTE_WIDTH-1:0] PERC_LOW       = 7'd8;
   localparam logic [NOTE_WIDTH-1:0] PERC_HIGH      = 7'd15;
   localparam logic [NOTE_WIDTH-1:0] ALL_KEY_RESET  = 7'd50;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_PROGRAM  = 2'd2,
      OP_OTHER    = 2'd3
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_DIRECT  = 3'd0,
      ST_ALL     = 3'd1,
      ST_PROGRAM = 3'd2,
      ST_PERC    = 3'd3,
      ST_IGNORED = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      REG_ALL_RELAYS_KEY = 1'd0
   } reg_index_type;

   typedef struct packed {
      logic [RELAY_WIDTH-1:0] relay_pattern;
      logic                   refresh;
      status_type             status;
   } result_type;

   typedef logic [NOTE_WIDTH-1:0] note_type;
   typedef logic [2:0]            relay_index_type;

   localparam note_type DIRECT_KEY_TABLE [DIRECT_KEYS] =
      '{7'd36, 7'd38, 7'd40, 7'd41, 7'd43, 7'd45, 7'd47, 7'd48};
   localparam relay_index_type RELAY_OF_KEY [DIRECT_KEYS] =
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd6, 3'd5, 3'd4};

endpackage

// ===== src/midi_note_relay_mapper.sv =====
// The input register feeds the decode and the result register, which drives rsp.
// Throughput: one beat per cycle unless rsp stalls; the channel and relay state
// update in the same cycle as the result register loads.
// Reset clears the instrument table and relays, sets the all-relays key to 50
// and empties both registers; the block takes beats from the next cycle on.
module midi_note_relay_mapper #(
   parameter int RELAY_COUNT = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mnrm_pkg::OP_WIDTH-1:0]       req_op,
   input  logic [mnrm_pkg::CHANNEL_WIDTH-1:0]  req_channel,
   input  logic [mnrm_pkg::NOTE_WIDTH-1:0]     req_key,
   input  logic [mnrm_pkg::NOTE_WIDTH-1:0]     req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mnrm_pkg::RELAY_WIDTH-1:0]    rsp_relay_pattern,
   output logic                                rsp_refresh,
   output logic [mnrm_pkg::STATUS_WIDTH-1:0]   rsp_status,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mnrm_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [mnrm_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [mnrm_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import mnrm_pkg::*;

   logic                     in_valid_ff;
   logic                     in_valid_in;
   op_type                   in_op_ff;
   logic [CHANNEL_WIDTH-1:0] in_channel_ff;
   note_type                 in_key_ff;
   note_type                 in_value_ff;

   logic                     out_valid_ff;
   logic                     out_valid_in;
   result_type               out_result_ff;

   note_type                 instrument_ff [CHANNELS];
   logic [RELAY_WIDTH-1:0]   relay_on_ff;
   logic [RELAY_WIDTH-1:0]   relay_on_in;

   note_type                 all_key;
   result_type               result;
   logic                     advance;
   logic                     req_take;

   mnrm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .all_key (all_key)
   );

   mnrm_decode #(
      .RELAY_COUNT (RELAY_COUNT)
   ) u_decode (
      .op         (in_op_ff),
      .key        (in_key_ff),
      .value      (in_value_ff),
      .instrument (instrument_ff[in_channel_ff]),
      .relay_on   (relay_on_ff),
      .all_key    (all_key),
      .result     (result)
   );

   // result register frees when empty or drained this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = reset || (in_valid_ff && !advance);
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);
   assign relay_on_in  = advance ? result.relay_pattern : relay_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         relay_on_ff  <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            instrument_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         relay_on_ff  <= relay_on_in;
         if (advance && in_op_ff == OP_PROGRAM) begin
            instrument_ff[in_channel_ff] <= in_value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff      <= op_type'(req_op);
         in_channel_ff <= req_channel;
         in_key_ff     <= req_key;
         in_value_ff   <= req_value;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_relay_pattern = out_result_ff.relay_pattern;
   assign rsp_refresh       = out_result_ff.refresh;
   assign rsp_status        = out_result_ff.status;

endmodule

// ===== src/mnrm_csr.sv =====
// APB-style configuration register file holding the all-relays key.
module mnrm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mnrm_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [mnrm_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [mnrm_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output logic [mnrm_pkg::NOTE_WIDTH-1:0]     all_key
);
   import mnrm_pkg::*;

   note_type      all_key_ff;
   note_type      all_key_in;
   reg_index_type index;
   logic          hit;

   assign pready = 1'b1;
   assign index  = reg_index_type'(paddr[CSR_ADDR_WIDTH-1]);
   assign hit    = (paddr[CSR_ADDR_WIDTH-1:2] == 1'(REG_ALL_RELAYS_KEY));

   always_comb begin
      all_key_in = all_key_ff;
      if (psel && penable && pwrite && pready && hit) begin
         all_key_in = pwdata[NOTE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         all_key_ff <= ALL_KEY_RESET;
      end else begin
         all_key_ff <= all_key_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_ALL_RELAYS_KEY: prdata = {{(CSR_DATA_WIDTH-NOTE_WIDTH){1'b0}}, all_key_ff};
         default:            prdata = '0;
      endcase
   end

   assign all_key = all_key_ff;

endmodule

// ===== src/mnrm_decode.sv =====
// Event decode: next relay pattern, refresh flag and status for one event.
module mnrm_decode #(
   parameter int RELAY_COUNT = 8
) (
   input  mnrm_pkg::op_type                 op,
   input  logic [mnrm_pkg::NOTE_WIDTH-1:0]  key,
   input  logic [mnrm_pkg::NOTE_WIDTH-1:0]  value,
   input  logic [mnrm_pkg::NOTE_WIDTH-1:0]  instrument,
   input  logic [mnrm_pkg::RELAY_WIDTH-1:0] relay_on,
   input  logic [mnrm_pkg::NOTE_WIDTH-1:0]  all_key,
   output mnrm_pkg::result_type             result
);
   import mnrm_pkg::*;

   localparam logic [RELAY_WIDTH-1:0] RelayMask =
      RELAY_WIDTH'((RELAY_WIDTH+1)'(1) << RELAY_COUNT) - RELAY_WIDTH'(1);

   logic                   on;
   logic                   found;
   relay_index_type        slot_relay;
   logic                   perc;
   logic [RELAY_WIDTH-1:0] bit_mask;

   always_comb begin
      found      = 1'b0;
      slot_relay = '0;
      for (int i = 0; i < DIRECT_KEYS; i++) begin
         if (!found && DIRECT_KEY_TABLE[i] == key) begin
            found      = 1'b1;
            slot_relay = RELAY_OF_KEY[i];
         end
      end
   end

   assign on       = (op == OP_NOTE_ON) && (value != '0);
   assign perc     = (instrument >= PERC_LOW) && (instrument <= PERC_HIGH);
   assign bit_mask = RELAY_WIDTH'(1) << slot_relay;

   always_comb begin
      result.relay_pattern = relay_on;
      result.refresh       = 1'b0;
      result.status        = ST_IGNORED;
      priority if (op == OP_PROGRAM) begin
         result.status = ST_PROGRAM;
      end else if (perc) begin
         result.status = ST_PERC;
      end else if (op == OP_NOTE_ON || op == OP_NOTE_OFF) begin
         if (found) begin
            if (4'(slot_relay) < 4'(RELAY_COUNT)) begin
               result.relay_pattern = on ? (relay_on | bit_mask) : (relay_on & ~bit_mask);
               result.refresh       = 1'b1;
               result.status        = ST_DIRECT;
            end
         end else if (key == all_key && key != '0) begin
            result.relay_pattern = on ? (relay_on | RelayMask) : (relay_on & ~RelayMask);
            result.refresh       = 1'b1;
            result.status        = ST_ALL;
         end
      end else begin
         result.status = ST_IGNORED;
      end
   end

endmodule
